[rtl/cgh_pkg.sv]
// Shared types, codes and cell-cost arithmetic for the cost grid block.
// No dependencies; imported by cgh_walk and cost_grid_hit_and_ray_clear.
`default_nettype none

package cgh_pkg;

    typedef logic [7:0] t_coord;
    typedef logic [7:0] t_cost;
    typedef logic [8:0] t_dim;
    typedef logic [1:0] t_req;
    typedef logic [1:0] t_cfg_idx;

    localparam t_cost UNKNOWN_COST   = 8'd255;
    localparam t_cost MAX_KNOWN_COST = 8'd254;

    localparam t_req REQ_HIT    = 2'd0;
    localparam t_req REQ_RAY    = 2'd1;
    localparam t_req REQ_READ   = 2'd2;
    localparam t_req REQ_UNUSED = 2'd3;

    localparam t_cfg_idx CFG_HIT_INC   = 2'd0;
    localparam t_cfg_idx CFG_CLEAR_DEC = 2'd1;
    localparam t_cfg_idx CFG_WIDTH     = 2'd2;
    localparam t_cfg_idx CFG_HEIGHT    = 2'd3;

    // hit: unknown becomes free, otherwise add and saturate below unknown
    function automatic t_cost f_hit_cost(input t_cost c, input t_cost inc);
        logic [8:0] sum;
        sum = {1'b0, c} + {1'b0, inc};
        if (c == UNKNOWN_COST) begin
            return 8'd0;
        end else if (sum < {1'b0, MAX_KNOWN_COST}) begin
            return sum[7:0];
        end else begin
            return MAX_KNOWN_COST;
        end
    endfunction

    // ray pass: unknown becomes free, otherwise subtract with floor at zero
    function automatic t_cost f_lower_cost(input t_cost c, input t_cost dec);
        if (c == UNKNOWN_COST || c < dec) begin
            return 8'd0;
        end else begin
            return c - dec;
        end
    endfunction

    // one step of one axis toward the target
    function automatic t_coord f_step(input t_coord a, input t_coord target);
        if (a > target) begin
            return a - 8'd1;
        end else if (a < target) begin
            return a + 8'd1;
        end else begin
            return a;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/cgh_walk.sv]
// Ray walker: steps a cell position toward the robot cell, both axes at once.
// Depends on cgh_pkg (coordinate type, step function).
`default_nettype none

module cgh_walk
    import cgh_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_load,
    input  wire logic   i_adv,
    input  wire t_coord i_start_x,
    input  wire t_coord i_start_y,
    input  wire t_coord i_robot_x,
    input  wire t_coord i_robot_y,
    output t_coord      o_x,
    output t_coord      o_y,
    output logic        o_last
);

    t_coord r_x, r_y, r_rx, r_ry;

    // the obstacle cell itself is not visited: load with the first step taken
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x  <= f_step(i_start_x, i_robot_x);
            r_y  <= f_step(i_start_y, i_robot_y);
            r_rx <= i_robot_x;
            r_ry <= i_robot_y;
        end else if (i_adv) begin
            r_x <= f_step(r_x, r_rx);
            r_y <= f_step(r_y, r_ry);
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_last = (r_x == r_rx) && (r_y == r_ry);

endmodule

`default_nettype wire

[rtl/cost_grid_hit_and_ray_clear.sv]
// Cost grid with hit updates, clearing rays and reads; grid memory, sequencer
// and output register. Depends on cgh_pkg and cgh_walk.
//
// The grid is one GRID_SIDE x GRID_SIDE byte memory with one read and one write
// port and a registered read. After reset the block writes 255 into every cell
// and holds o_stall high meanwhile; configuration writes are taken at any time.
// Items are handled one at a time. A hit or read goes from acceptance through the
// read state and the finish state into the output register; a clear ray walks its
// cells (up to 255) in the walk state, then passes the wait and finish states: the
// memory port does one read-modify-write per cell, reads and writes of neighboring
// cells overlap. Requests with the obstacle cell out of range, unused types and
// rays whose obstacle is the robot cell go straight to the finish state. o_stall
// stays high until the result is loaded, so the next item waits for that load; a
// full output register held by the receiver delays the load.
// The next item is accepted while a result still waits in the output register.
`default_nettype none

module cost_grid_hit_and_ray_clear
    import cgh_pkg::*;
#(
    parameter int GRID_SIDE = 256
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    // request channel
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_req     i_req_type,
    input  wire t_coord   i_cell_x,
    input  wire t_coord   i_cell_y,
    input  wire t_coord   i_robot_x,
    input  wire t_coord   i_robot_y,
    // result channel
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_cost         o_cost,
    output logic [7:0]    o_cells_changed,
    output logic          o_in_range,
    // configuration writes
    input  wire logic     i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire t_cfg_idx i_cfg_index,
    input  wire t_dim     i_cfg_data
);

    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_WFIN  = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    function automatic logic [AW-1:0] f_addr(input t_coord x, input t_coord y);
        return AW'(32'(y) * GRID_SIDE + 32'(x));
    endfunction

    // configuration
    t_cost r_inc, r_dec;
    t_dim  r_width, r_height;

    function automatic logic f_in_range(input t_coord x, input t_coord y,
                                        input t_dim w, input t_dim h);
        return ({1'b0, x} < w) && ({1'b0, y} < h) &&
               (32'(x) < GRID_SIDE) && (32'(y) < GRID_SIDE);
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc    <= 8'd10;
            r_dec    <= 8'd5;
            r_width  <= 9'd256;
            r_height <= 9'd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HIT_INC:   r_inc    <= i_cfg_data[7:0];
                CFG_CLEAR_DEC: r_dec    <= i_cfg_data[7:0];
                CFG_WIDTH:     r_width  <= i_cfg_data;
                CFG_HEIGHT:    r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // grid memory
    t_cost r_mem [DEPTH];
    t_cost r_rd;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    t_cost         wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    // ray walker
    logic   walk_load, walk_adv, walk_last;
    t_coord walk_x, walk_y;

    cgh_walk u_walk (
        .i_clk     (i_clk),
        .i_load    (walk_load),
        .i_adv     (walk_adv),
        .i_start_x (i_cell_x),
        .i_start_y (i_cell_y),
        .i_robot_x (i_robot_x),
        .i_robot_y (i_robot_y),
        .o_x       (walk_x),
        .o_y       (walk_y),
        .o_last    (walk_last)
    );

    // sequencer
    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    t_req          r_req, n_req;
    logic [AW-1:0] r_addr, n_addr;
    logic          r_pend_v, n_pend_v;
    logic          r_pend_ok, n_pend_ok;
    logic [AW-1:0] r_pend_addr, n_pend_addr;
    t_cost         r_res_cost, n_res_cost;
    logic [7:0]    r_res_cnt, n_res_cnt;
    logic          r_res_ok, n_res_ok;
    logic          r_ov, n_ov;
    logic          out_load;

    logic          in_ok;
    logic [AW-1:0] in_addr, walk_addr;

    assign in_ok     = f_in_range(i_cell_x, i_cell_y, r_width, r_height);
    assign in_addr   = f_addr(i_cell_x, i_cell_y);
    assign walk_addr = f_addr(walk_x, walk_y);

    assign o_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_req       = r_req;
        n_addr      = r_addr;
        n_pend_v    = r_pend_v;
        n_pend_ok   = r_pend_ok;
        n_pend_addr = r_pend_addr;
        n_res_cost  = r_res_cost;
        n_res_cnt   = r_res_cnt;
        n_res_ok    = r_res_ok;
        n_ov        = r_ov && i_stall;
        out_load    = 1'b0;
        walk_load   = 1'b0;
        walk_adv    = 1'b0;
        rd_addr     = in_addr;
        wr_en       = 1'b0;
        wr_addr     = r_addr;
        wr_data     = UNKNOWN_COST;

        // retire the cell read in the previous cycle on a ray
        if ((r_state == ST_WALK || r_state == ST_WFIN) && r_pend_v && r_pend_ok) begin
            wr_en     = 1'b1;
            wr_addr   = r_pend_addr;
            wr_data   = f_lower_cost(r_rd, r_dec);
            n_res_cnt = r_res_cnt + 8'd1;
        end

        case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = UNKNOWN_COST;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_req      = i_req_type;
                    n_addr     = in_addr;
                    n_res_cost = 8'd0;
                    n_res_cnt  = 8'd0;
                    n_res_ok   = in_ok && (i_req_type != REQ_UNUSED);
                    n_pend_v   = 1'b0;
                    if ((i_req_type == REQ_HIT || i_req_type == REQ_READ) && in_ok) begin
                        n_state = ST_RD;
                    end else if (i_req_type == REQ_RAY && in_ok &&
                                 (i_cell_x != i_robot_x || i_cell_y != i_robot_y)) begin
                        walk_load = 1'b1;
                        n_state   = ST_WALK;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_RD: begin
                if (r_req == REQ_HIT) begin
                    wr_en      = 1'b1;
                    wr_addr    = r_addr;
                    wr_data    = f_hit_cost(r_rd, r_inc);
                    n_res_cost = f_hit_cost(r_rd, r_inc);
                end else begin
                    n_res_cost = r_rd;
                end
                n_state = ST_FIN;
            end
            ST_WALK: begin
                // consecutive ray cells always differ, so no read/write clash
                rd_addr     = walk_addr;
                walk_adv    = 1'b1;
                n_pend_v    = 1'b1;
                n_pend_ok   = f_in_range(walk_x, walk_y, r_width, r_height);
                n_pend_addr = walk_addr;
                if (walk_last) begin
                    n_state = ST_WFIN;
                end
            end
            ST_WFIN: begin
                n_pend_v = 1'b0;
                n_state  = ST_FIN;
            end
            ST_FIN: begin
                if (!r_ov || !i_stall) begin
                    out_load = 1'b1;
                    n_ov     = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_ov     <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ov     <= n_ov;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_addr      <= n_addr;
        r_pend_ok   <= n_pend_ok;
        r_pend_addr <= n_pend_addr;
        r_res_cost  <= n_res_cost;
        r_res_cnt   <= n_res_cnt;
        r_res_ok    <= n_res_ok;
        if (out_load) begin
            o_cost          <= r_res_cost;
            o_cells_changed <= r_res_cnt;
            o_in_range      <= r_res_ok;
        end
    end

    assign o_valid = r_ov;

endmodule

`default_nettype wire

[sim/cost_grid_hit_and_ray_clear_test.sv]
// Self-checking test for cost_grid_hit_and_ray_clear: hit, clearing ray and read requests
// checked against a cell-by-cell copy of the grid kept here.
// Depends on cgh_pkg and the cost_grid_hit_and_ray_clear RTL.
`default_nettype none

module cost_grid_hit_and_ray_clear_test;
    import cgh_pkg::*;

    localparam int QUIET_LIMIT = 300000;   // covers the clearing pass after reset
    localparam int LONG_HOLD   = 400;
    localparam int PHASE_ITEMS = 230;

    typedef struct {
        t_req        kind;
        t_coord      x;
        t_coord      y;
        t_coord      rx;
        t_coord      ry;
        int unsigned gap;
        bit          drain;
    } t_cell_req;

    typedef struct {
        t_cost      cost;
        logic [7:0] changed;
        logic       in_range;
    } t_cell_result;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_valid         = 1'b0;
    logic       o_stall;
    t_req       i_req_type      = REQ_HIT;
    t_coord     i_cell_x        = '0;
    t_coord     i_cell_y        = '0;
    t_coord     i_robot_x       = '0;
    t_coord     i_robot_y       = '0;
    logic       o_valid;
    logic       i_stall         = 1'b0;
    t_cost      o_cost;
    logic [7:0] o_cells_changed;
    logic       o_in_range;
    logic       i_cfg_valid     = 1'b0;
    logic       o_cfg_ready;
    t_cfg_idx   i_cfg_index     = CFG_HIT_INC;
    t_dim       i_cfg_data      = '0;

    cost_grid_hit_and_ray_clear dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_cell_x        (i_cell_x),
        .i_cell_y        (i_cell_y),
        .i_robot_x       (i_robot_x),
        .i_robot_y       (i_robot_y),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_cost          (o_cost),
        .o_cells_changed (o_cells_changed),
        .o_in_range      (o_in_range),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // grid copy and register copies
    t_cost grid_copy [0:65535];
    t_cost hit_inc   = 8'd10;
    t_cost clear_dec = 8'd5;
    t_dim  width     = 9'd256;
    t_dim  height    = 9'd256;

    t_cell_req    req_pending [$];
    t_cell_result result_due  [$];

    int   fail_count   = 0;
    int   result_seq   = 0;
    int   idle_run     = 0;
    int   rx_wait      = 0;
    int   hold_left    = 0;
    int   quiet_cycles = 0;
    bit   rx_calm      = 1'b0;
    logic hold_go      = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit on_grid(input t_coord x, input t_coord y);
        return ({1'b0, x} < width) && ({1'b0, y} < height);
    endfunction

    function automatic t_cell_result apply_request(input t_cell_req r);
        t_cell_result res;
        t_coord       ax;
        t_coord       ay;
        t_cost        c;
        int unsigned  sum;
        logic         ok;
        res.cost    = '0;
        res.changed = '0;
        ok = on_grid(r.x, r.y);
        case (r.kind)
            REQ_HIT: begin
                if (ok) begin
                    c   = grid_copy[{r.y, r.x}];
                    sum = int'(c) + int'(hit_inc);
                    if (c == UNKNOWN_COST) begin
                        res.cost = '0;
                    end else if (sum < MAX_KNOWN_COST) begin
                        res.cost = t_cost'(sum);
                    end else begin
                        res.cost = MAX_KNOWN_COST;
                    end
                    grid_copy[{r.y, r.x}] = res.cost;
                end
            end
            REQ_RAY: begin
                if (ok) begin
                    ax = r.x;
                    ay = r.y;
                    while (ax != r.rx || ay != r.ry) begin
                        if (ax > r.rx) ax = ax - 8'd1;
                        else if (ax < r.rx) ax = ax + 8'd1;
                        if (ay > r.ry) ay = ay - 8'd1;
                        else if (ay < r.ry) ay = ay + 8'd1;
                        // off-grid cells are passed over but not counted
                        if (on_grid(ax, ay)) begin
                            c = grid_copy[{ay, ax}];
                            if (c == UNKNOWN_COST || c < clear_dec) begin
                                grid_copy[{ay, ax}] = '0;
                            end else begin
                                grid_copy[{ay, ax}] = c - clear_dec;
                            end
                            res.changed = res.changed + 8'd1;
                        end
                    end
                end
            end
            REQ_READ: begin
                if (ok) res.cost = grid_copy[{r.y, r.x}];
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        res.in_range = ok;
        return res;
    endfunction

    // mostly near the origin or the grid edge, sometimes anywhere
    function automatic t_coord pick_coord(input t_dim span);
        int unsigned r;
        int unsigned top;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            top = (span > 24) ? 24 : span;
            return t_coord'($urandom_range(0, top));
        end else if (r < 85) begin
            top = (span > 255) ? 255 : span;
            return t_coord'($urandom_range((top > 3) ? top - 3 : 0, top));
        end
        return t_coord'($urandom_range(0, 255));
    endfunction

    function automatic t_coord near_coord(input t_coord a);
        int v;
        v = int'(a) + int'($urandom_range(0, 20)) - 10;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return t_coord'(v);
    endfunction

    function automatic t_cell_req random_request(input bit tx_calm);
        t_cell_req   r;
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) r.kind = REQ_HIT;
        else if (sel < 70) r.kind = REQ_RAY;
        else if (sel < 95) r.kind = REQ_READ;
        else r.kind = REQ_UNUSED;
        r.x  = pick_coord(width);
        r.y  = pick_coord(height);
        r.rx = t_coord'($urandom_range(0, 255));
        r.ry = t_coord'($urandom_range(0, 255));
        if (r.kind == REQ_RAY) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) begin
                r.rx = near_coord(r.x);
                r.ry = near_coord(r.y);
            end else if (sel < 95) begin
                r.rx = pick_coord(width);
                r.ry = pick_coord(height);
            end
        end else if (r.kind == REQ_UNUSED) begin
            r.x = t_coord'($urandom_range(0, 255));
            r.y = t_coord'($urandom_range(0, 255));
        end
        r.gap   = tx_calm ? 0 : $urandom_range(0, 12);
        r.drain = ($urandom_range(0, 99) < 2);
        return r;
    endfunction

    task automatic add_req(input t_req kind, input t_coord x, input t_coord y,
                           input t_coord rx, input t_coord ry);
        t_cell_req r;
        r.kind  = kind;
        r.x     = x;
        r.y     = y;
        r.rx    = rx;
        r.ry    = ry;
        r.gap   = $urandom_range(0, 12);
        r.drain = 1'b0;
        req_pending.insert(req_pending.size(), r);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_dim val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input t_cost inc, input t_cost dec, input t_dim w, input t_dim h);
        write_reg(CFG_HIT_INC, {1'b0, inc});
        write_reg(CFG_CLEAR_DEC, {1'b0, dec});
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        hit_inc   = inc;
        clear_dec = dec;
        width     = w;
        height    = h;
    endtask

    // block is idle once every item is in and every result is out
    task automatic wait_idle();
        while (req_pending.size() != 0 || result_due.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin
        bit took;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            idle_run = 0;
        end else begin
            took = i_valid && !o_stall;
            if (took) begin
                result_due.insert(result_due.size(), apply_request(req_pending[0]));
                void'(req_pending.pop_front());
                idle_run = 0;
            end
            if (!i_valid || took) begin
                if (req_pending.size() != 0 && idle_run >= req_pending[0].gap &&
                    (!req_pending[0].drain || result_due.size() == 0)) begin
                    i_valid    <= 1'b1;
                    i_req_type <= req_pending[0].kind;
                    i_cell_x   <= req_pending[0].x;
                    i_cell_y   <= req_pending[0].y;
                    i_robot_x  <= req_pending[0].rx;
                    i_robot_y  <= req_pending[0].ry;
                end else begin
                    i_valid  <= 1'b0;
                    idle_run = idle_run + 1;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        t_cell_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait = 0;
            hold_left = 0;
        end else begin
            if (hold_go) hold_left = LONG_HOLD;
            if (o_valid && !i_stall) begin
                result_seq = result_seq + 1;
                if (result_due.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("result %0d arrived with nothing outstanding", result_seq);
                end else begin
                    want = result_due.pop_front();
                    if (o_cost !== want.cost || o_cells_changed !== want.changed ||
                        o_in_range !== want.in_range) begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10)
                            $display("result %0d: expected cost %0d changed %0d in_range %0d, %s",
                                     result_seq, want.cost, want.changed, want.in_range,
                                     $sformatf("got cost %0d changed %0d in_range %0d",
                                               o_cost, o_cells_changed, o_in_range));
                    end
                end
                rx_wait = rx_calm ? 0 : $urandom_range(0, 12);
            end else if (o_valid && rx_wait > 0) begin
                rx_wait = rx_wait - 1;
            end
            if (hold_left > 0) hold_left = hold_left - 1;
            i_stall <= (hold_left > 0) || (rx_wait > 0);
        end
    end

    // watchdog: too long without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int n_items;
        bit tx_calm;
        foreach (grid_copy[i]) grid_copy[i] = UNKNOWN_COST;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values; items wait out the clearing pass
        @(negedge i_clk);
        add_req(REQ_READ,   8'd3,   8'd4,   8'd0,   8'd0);
        add_req(REQ_HIT,    8'd3,   8'd4,   8'd0,   8'd0);
        add_req(REQ_HIT,    8'd3,   8'd4,   8'd0,   8'd0);
        add_req(REQ_READ,   8'd3,   8'd4,   8'd0,   8'd0);
        add_req(REQ_HIT,    8'd0,   8'd0,   8'd255, 8'd255);
        add_req(REQ_HIT,    8'd255, 8'd255, 8'd0,   8'd0);
        add_req(REQ_READ,   8'd255, 8'd255, 8'd0,   8'd0);
        add_req(REQ_RAY,    8'd3,   8'd4,   8'd3,   8'd4);
        add_req(REQ_RAY,    8'd0,   8'd0,   8'd255, 8'd255);
        add_req(REQ_READ,   8'd128, 8'd128, 8'd0,   8'd0);
        add_req(REQ_RAY,    8'd3,   8'd0,   8'd3,   8'd8);
        add_req(REQ_READ,   8'd3,   8'd4,   8'd0,   8'd0);
        add_req(REQ_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255);
        add_req(REQ_RAY,    8'd255, 8'd0,   8'd0,   8'd255);

        // tiny grid, saturating hit, flooring decrement
        wait_idle();
        set_regs(8'd254, 8'd255, 9'd4, 9'd6);
        @(negedge i_clk);
        add_req(REQ_HIT,  8'd3,  8'd5,  8'd0,  8'd0);
        add_req(REQ_HIT,  8'd3,  8'd5,  8'd0,  8'd0);
        add_req(REQ_HIT,  8'd3,  8'd5,  8'd0,  8'd0);
        add_req(REQ_HIT,  8'd4,  8'd0,  8'd0,  8'd0);
        add_req(REQ_READ, 8'd0,  8'd6,  8'd0,  8'd0);
        add_req(REQ_RAY,  8'd10, 8'd10, 8'd0,  8'd0);
        add_req(REQ_RAY,  8'd3,  8'd0,  8'd3,  8'd5);
        add_req(REQ_READ, 8'd3,  8'd5,  8'd0,  8'd0);
        add_req(REQ_RAY,  8'd0,  8'd0,  8'd20, 8'd20);
        add_req(REQ_READ, 8'd3,  8'd3,  8'd0,  8'd0);

        for (int ph = 0; ph < 9; ph++) begin
            wait_idle();
            n_items = PHASE_ITEMS;
            case (ph)
                0: set_regs(8'd254, 8'd0, 9'd256, 9'd256);
                1: set_regs(8'd0, 8'd255, 9'd1, 9'd1);
                2: set_regs(t_cost'($urandom_range(0, 254)), t_cost'($urandom_range(0, 255)),
                            9'd16, 9'd20);
                3: begin
                    set_regs(8'd1, 8'd1, 9'd0, 9'd256);
                    n_items = 40;
                end
                4: begin
                    set_regs(t_cost'($urandom_range(0, 254)), t_cost'($urandom_range(0, 255)),
                             9'd256, 9'd0);
                    n_items = 40;
                end
                5: set_regs(8'd10, 8'd5, 9'd8, 9'd8);
                default: set_regs(t_cost'($urandom_range(0, 254)),
                                  t_cost'($urandom_range(0, 255)),
                                  t_dim'($urandom_range(1, 256)),
                                  t_dim'($urandom_range(1, 256)));
            endcase
            tx_calm = (ph == 2 || ph == 5);
            @(negedge i_clk);
            rx_calm = (ph == 5 || ph == 6);
            for (int k = 0; k < n_items; k++)
                req_pending.insert(req_pending.size(), random_request(tx_calm));
            if (ph == 2) begin
                // receiver holds off while back-to-back items keep coming
                @(posedge i_clk);
                hold_go <= 1'b1;
                @(posedge i_clk);
                hold_go <= 1'b0;
            end
        end

        while (req_pending.size() != 0 || result_due.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/cgh_pkg.sv
rtl/cgh_walk.sv
rtl/cost_grid_hit_and_ray_clear.sv
sim/cost_grid_hit_and_ray_clear_test.sv
